// ===== hdl/dac_nvm_store_bitbang_sequencer_defines.svh =====
// assertion macros for the store sequencer checker
`ifndef DAC_NVM_STORE_BITBANG_SEQUENCER_DEFINES_SVH
`define DAC_NVM_STORE_BITBANG_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DNSS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DNSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dnss_pkg.sv =====
// types and constants shared by the store sequencer modules
package dnss_pkg;

    typedef struct packed {
        logic drv;
        logic sda;
        logic scl;
    } lines_t;

    typedef struct packed {
        logic [2:0] head_bits;
        logic [7:0] timing_address;
        logic [7:0] command_one;
        logic [7:0] command_two;
        logic [6:0] device_address;
        logic [7:0] setup_ticks;
        logic [7:0] hold_ticks;
        logic [7:0] period_ticks;
    } cfg_t;

    typedef struct packed {
        logic clock_line;
        logic data_level;
        logic data_drive;
        logic bus_handed_back;
        logic busy_res;
        logic finished;
    } res_t;

    localparam lines_t LINES_IDLE  = '{drv: 1'b0, sda: 1'b1, scl: 1'b1};
    localparam lines_t LINES_DRIVE = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};

    localparam logic [7:0] SETUP_RESET  = 8'd2;
    localparam logic [7:0] HOLD_RESET   = 8'd2;
    localparam logic [7:0] PERIOD_RESET = 8'd4;

    // register indexes
    localparam logic [2:0] REG_HEAD_BITS      = 3'd0;
    localparam logic [2:0] REG_TIMING_ADDRESS = 3'd1;
    localparam logic [2:0] REG_COMMAND_ONE    = 3'd2;
    localparam logic [2:0] REG_COMMAND_TWO    = 3'd3;
    localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd4;
    localparam logic [2:0] REG_SETUP_TICKS    = 3'd5;
    localparam logic [2:0] REG_HOLD_TICKS     = 3'd6;
    localparam logic [2:0] REG_PERIOD_TICKS   = 3'd7;

    // sequence steps
    localparam logic [4:0] STEP_IDLE     = 5'd0;
    localparam logic [4:0] STEP_START_A  = 5'd1;
    localparam logic [4:0] STEP_HEAD_A   = 5'd2;
    localparam logic [4:0] STEP_STOP_A   = 5'd3;
    localparam logic [4:0] STEP_START_B  = 5'd4;
    localparam logic [4:0] STEP_TADDR_A  = 5'd5;
    localparam logic [4:0] STEP_CMD1     = 5'd6;
    localparam logic [4:0] STEP_STOP_B   = 5'd7;
    localparam logic [4:0] STEP_START_C  = 5'd8;
    localparam logic [4:0] STEP_DEV      = 5'd9;
    localparam logic [4:0] STEP_CMD2_REP = 5'd10;
    localparam logic [4:0] STEP_STOP_C   = 5'd11;
    localparam logic [4:0] STEP_WAIT     = 5'd12;
    localparam logic [4:0] STEP_START_D  = 5'd13;
    localparam logic [4:0] STEP_HEAD_B   = 5'd14;
    localparam logic [4:0] STEP_STOP_D   = 5'd15;
    localparam logic [4:0] STEP_START_E  = 5'd16;
    localparam logic [4:0] STEP_TADDR_B  = 5'd17;
    localparam logic [4:0] STEP_CMD2     = 5'd18;
    localparam logic [4:0] STEP_STOP_E   = 5'd19;
    localparam logic [4:0] STEP_DONE     = 5'd20;

    // phases of one start, stop or byte
    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_SETUP = 3'd1;
    localparam logic [2:0] PH_HIGH  = 3'd2;
    localparam logic [2:0] PH_TAIL  = 3'd3;
    localparam logic [2:0] PH_ACK   = 3'd4;

    // acknowledge slot sub-states, carried in the bit position
    localparam logic [2:0] ACK_RELEASE = 3'd0;
    localparam logic [2:0] ACK_RISE    = 3'd1;
    localparam logic [2:0] ACK_HOLD    = 3'd2;
    localparam logic [2:0] ACK_POLL    = 3'd3;
    localparam logic [2:0] ACK_GAP     = 3'd4;
    localparam logic [2:0] ACK_FALL    = 3'd5;
    localparam logic [2:0] ACK_DRIVE   = 3'd6;

    localparam logic [2:0] HEAD_MSB = 3'd2;
    localparam logic [2:0] BYTE_MSB = 3'd7;

endpackage

// ===== hdl/dnss_core.sv =====
// sequencer state and per-tick next-state logic
module dnss_core #(
    parameter int STORE_WAIT_TICKS = 10000,
    parameter int ACK_POLL_LIMIT   = 250,
    parameter int COMMAND_REPEATS  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  dnss_pkg::cfg_t cfg,
    input  logic           start_request,
    input  logic           sda_sample,
    output dnss_pkg::res_t res
);
    import dnss_pkg::*;

    localparam int WAIT_MAX = (STORE_WAIT_TICKS > 255) ? STORE_WAIT_TICKS : 255;
    localparam int WW       = $clog2(WAIT_MAX + 1);
    localparam int PW       = (ACK_POLL_LIMIT > 1) ? $clog2(ACK_POLL_LIMIT) : 1;
    localparam int RW       = $clog2(COMMAND_REPEATS + 1);

    typedef enum logic [2:0] {
        EL_IDLE  = 3'd0,
        EL_START = 3'd1,
        EL_STOP  = 3'd2,
        EL_BYTE  = 3'd3,
        EL_WAIT  = 3'd4,
        EL_DONE  = 3'd5,
        EL_BAD   = 3'd6
    } elem_t;

    logic [4:0]    step_reg, step_next;
    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    bitpos_reg, bitpos_next;
    logic [RW-1:0] rep_reg, rep_next;
    logic [WW-1:0] wcnt_reg, wcnt_next;
    logic [PW-1:0] polls_reg, polls_next;
    lines_t        lines_reg, lines_next;

    elem_t         el;
    logic [7:0]    byte_val;
    logic          ack_none;
    logic          ack_exp;
    logic [WW-1:0] w_inc;
    logic          ge_setup, ge_hold, ge_period, ge_store;
    logic          poll_last;
    logic [RW-1:0] rep_inc;
    logic          done, byte_done, adv, fin;
    logic [4:0]    adv_to;

    // element decode of the current step
    always_comb
    begin
        el       = EL_BAD;
        byte_val = '0;
        ack_none = 1'b0;
        ack_exp  = 1'b0;
        unique case (step_reg) inside
            STEP_IDLE:
                el = EL_IDLE;
            STEP_START_A, STEP_START_B, STEP_START_C, STEP_START_D, STEP_START_E:
                el = EL_START;
            STEP_STOP_A, STEP_STOP_B, STEP_STOP_C, STEP_STOP_D, STEP_STOP_E:
                el = EL_STOP;
            STEP_HEAD_A, STEP_HEAD_B:
            begin
                el       = EL_BYTE;
                byte_val = {5'b0, cfg.head_bits};
                ack_none = 1'b1;
            end
            STEP_TADDR_A, STEP_TADDR_B:
            begin
                el       = EL_BYTE;
                byte_val = cfg.timing_address;
            end
            STEP_CMD1:
            begin
                el       = EL_BYTE;
                byte_val = cfg.command_one;
            end
            STEP_CMD2:
            begin
                el       = EL_BYTE;
                byte_val = cfg.command_two;
            end
            STEP_DEV:
            begin
                el       = EL_BYTE;
                byte_val = {cfg.device_address, 1'b0};
                ack_exp  = 1'b1;
            end
            STEP_CMD2_REP:
            begin
                el       = EL_BYTE;
                byte_val = cfg.command_two;
                ack_exp  = 1'b1;
            end
            STEP_WAIT:
                el = EL_WAIT;
            STEP_DONE:
                el = EL_DONE;
            default:
                el = EL_BAD;
        endcase
    end

    assign w_inc     = wcnt_reg + 1'b1;
    assign ge_setup  = w_inc >= WW'(cfg.setup_ticks);
    assign ge_hold   = w_inc >= WW'(cfg.hold_ticks);
    assign ge_period = w_inc >= WW'(cfg.period_ticks);
    assign ge_store  = w_inc >= WW'(STORE_WAIT_TICKS);
    assign poll_last = ({1'b0, polls_reg} + 1'b1) >= (PW + 1)'(ACK_POLL_LIMIT);
    assign rep_inc   = rep_reg + 1'b1;

    always_comb
    begin
        step_next   = step_reg;
        phase_next  = phase_reg;
        bitpos_next = bitpos_reg;
        rep_next    = rep_reg;
        wcnt_next   = wcnt_reg;
        polls_next  = polls_reg;
        lines_next  = lines_reg;
        done        = 1'b0;
        byte_done   = 1'b0;
        adv         = 1'b0;
        adv_to      = step_reg + 1'b1;
        fin         = 1'b0;

        unique case (el)
            EL_IDLE:
            begin
                if (start_request)
                begin
                    lines_next = LINES_DRIVE;
                    adv        = 1'b1;
                    adv_to     = STEP_START_A;
                end
            end
            EL_START:
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        lines_next = LINES_DRIVE;
                        phase_next = PH_SETUP;
                        wcnt_next  = '0;
                    end
                    PH_SETUP:
                    begin
                        wcnt_next = w_inc;
                        if (ge_setup)
                        begin
                            lines_next.sda = 1'b0;
                            phase_next     = PH_HIGH;
                            wcnt_next      = '0;
                        end
                    end
                    PH_HIGH:
                    begin
                        wcnt_next = w_inc;
                        if (ge_hold)
                        begin
                            lines_next.scl = 1'b0;
                            phase_next     = PH_TAIL;
                            wcnt_next      = '0;
                        end
                    end
                    PH_TAIL:
                    begin
                        wcnt_next = w_inc;
                        done      = ge_period;
                    end
                    default:
                    begin
                        phase_next = PH_LEAD;
                        wcnt_next  = '0;
                    end
                endcase
            end
            EL_STOP:
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        lines_next.sda = 1'b0;
                        lines_next.drv = 1'b1;
                        phase_next     = PH_SETUP;
                        wcnt_next      = '0;
                    end
                    PH_SETUP:
                    begin
                        wcnt_next = w_inc;
                        if (ge_setup)
                        begin
                            lines_next.scl = 1'b1;
                            phase_next     = PH_HIGH;
                            wcnt_next      = '0;
                        end
                    end
                    PH_HIGH:
                    begin
                        wcnt_next = w_inc;
                        if (ge_period)
                        begin
                            lines_next.sda = 1'b1;
                            phase_next     = PH_TAIL;
                            wcnt_next      = '0;
                        end
                    end
                    PH_TAIL:
                    begin
                        wcnt_next = w_inc;
                        done      = ge_period;
                    end
                    default:
                    begin
                        phase_next = PH_LEAD;
                        wcnt_next  = '0;
                    end
                endcase
            end
            EL_BYTE:
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        lines_next.sda = byte_val[bitpos_reg];
                        lines_next.drv = 1'b1;
                        phase_next     = PH_SETUP;
                        wcnt_next      = '0;
                    end
                    PH_SETUP:
                    begin
                        wcnt_next = w_inc;
                        if (ge_setup)
                        begin
                            lines_next.scl = 1'b1;
                            phase_next     = PH_HIGH;
                            wcnt_next      = '0;
                        end
                    end
                    PH_HIGH:
                    begin
                        wcnt_next = w_inc;
                        if (ge_period)
                        begin
                            lines_next.scl = 1'b0;
                            phase_next     = PH_TAIL;
                            wcnt_next      = '0;
                        end
                    end
                    PH_TAIL:
                    begin
                        wcnt_next = w_inc;
                        if (ge_hold)
                        begin
                            wcnt_next = '0;
                            if (bitpos_reg == 3'd0)
                            begin
                                phase_next = PH_ACK;
                            end
                            else
                            begin
                                bitpos_next = bitpos_reg - 1'b1;
                                phase_next  = PH_LEAD;
                            end
                        end
                    end
                    PH_ACK:
                    begin
                        if (ack_none)
                        begin
                            // head ends with sda low and scl high at once
                            lines_next = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
                            byte_done  = 1'b1;
                        end
                        else
                        begin
                            unique case (bitpos_reg)
                                ACK_RELEASE:
                                begin
                                    lines_next.drv = 1'b0;
                                    lines_next.sda = 1'b1;
                                    wcnt_next      = '0;
                                    bitpos_next    = ACK_RISE;
                                end
                                ACK_RISE:
                                begin
                                    wcnt_next = w_inc;
                                    if (ge_setup)
                                    begin
                                        lines_next.scl = 1'b1;
                                        wcnt_next      = '0;
                                        bitpos_next    = ACK_HOLD;
                                    end
                                end
                                ACK_HOLD:
                                begin
                                    wcnt_next = w_inc;
                                    if (ge_hold)
                                    begin
                                        polls_next  = '0;
                                        wcnt_next   = '0;
                                        bitpos_next = ACK_POLL;
                                    end
                                end
                                ACK_POLL:
                                begin
                                    if (sda_sample == ack_exp || poll_last)
                                    begin
                                        bitpos_next = ACK_GAP;
                                    end
                                    else
                                    begin
                                        polls_next = polls_reg + 1'b1;
                                    end
                                end
                                ACK_GAP:
                                begin
                                    wcnt_next   = '0;
                                    bitpos_next = ACK_FALL;
                                end
                                ACK_FALL:
                                begin
                                    wcnt_next = w_inc;
                                    if (ge_setup)
                                    begin
                                        lines_next.scl = 1'b0;
                                        wcnt_next      = '0;
                                        bitpos_next    = ACK_DRIVE;
                                    end
                                end
                                ACK_DRIVE:
                                begin
                                    wcnt_next = w_inc;
                                    if (ge_hold)
                                    begin
                                        lines_next.drv = 1'b1;
                                        byte_done      = 1'b1;
                                    end
                                end
                                default:
                                    bitpos_next = ACK_RELEASE;
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEAD;
                        wcnt_next  = '0;
                    end
                endcase

                if (byte_done)
                begin
                    if (step_reg == STEP_DEV)
                    begin
                        rep_next = '0;
                        adv      = 1'b1;
                    end
                    else if (step_reg == STEP_CMD2_REP)
                    begin
                        rep_next = rep_inc;
                        if (rep_inc < RW'(COMMAND_REPEATS))
                        begin
                            phase_next  = PH_LEAD;
                            wcnt_next   = '0;
                            bitpos_next = BYTE_MSB;
                            polls_next  = '0;
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
            end
            EL_WAIT:
            begin
                wcnt_next = w_inc;
                done      = ge_store;
            end
            EL_DONE:
            begin
                fin        = 1'b1;
                lines_next = LINES_IDLE;
                rep_next   = '0;
                adv        = 1'b1;
                adv_to     = STEP_IDLE;
            end
            default:
            begin
                lines_next = LINES_IDLE;
                adv        = 1'b1;
                adv_to     = STEP_IDLE;
            end
        endcase

        if (done)
        begin
            adv = 1'b1;
        end

        if (adv)
        begin
            step_next   = adv_to;
            phase_next  = PH_LEAD;
            wcnt_next   = '0;
            polls_next  = '0;
            bitpos_next = (adv_to == STEP_HEAD_A || adv_to == STEP_HEAD_B) ? HEAD_MSB
                                                                           : BYTE_MSB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_IDLE;
            phase_reg  <= PH_LEAD;
            bitpos_reg <= BYTE_MSB;
            rep_reg    <= '0;
            wcnt_reg   <= '0;
            polls_reg  <= '0;
            lines_reg  <= LINES_IDLE;
        end
        else if (step_en)
        begin
            step_reg   <= step_next;
            phase_reg  <= phase_next;
            bitpos_reg <= bitpos_next;
            rep_reg    <= rep_next;
            wcnt_reg   <= wcnt_next;
            polls_reg  <= polls_next;
            lines_reg  <= lines_next;
        end
    end

    assign res.clock_line      = lines_next.scl;
    assign res.data_level      = lines_next.sda;
    assign res.data_drive      = lines_next.drv;
    assign res.bus_handed_back = (step_next == STEP_IDLE);
    assign res.busy_res        = (step_next != STEP_IDLE);
    assign res.finished        = fin;

endmodule

// ===== hdl/dac_nvm_store_bitbang_sequencer.sv =====
// top level of the store sequencer: config registers, tick handshake, result register
// Each accepted input word is one bus tick and yields exactly one result word, in the
// next cycle through the result register. A new tick is taken every cycle; in_ready
// drops only while the result register holds a word that out_ready has not taken.
// The sequencer state advances once per accepted tick, so line timing in ticks
// follows setup_ticks, hold_ticks and period_ticks. Configuration writes are
// taken every cycle and should be made while the sequence is idle.
module dac_nvm_store_bitbang_sequencer #(
    parameter int STORE_WAIT_TICKS = 10000,
    parameter int ACK_POLL_LIMIT   = 250,
    parameter int COMMAND_REPEATS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       start_request,
    input  logic       sda_sample,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       clock_line,
    output logic       data_level,
    output logic       data_drive,
    output logic       bus_handed_back,
    output logic       busy_res,
    output logic       finished,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import dnss_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic out_valid_reg, out_valid_next;
    res_t res_reg;
    res_t res;
    logic in_accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEAD_BITS:      cfg_next.head_bits      = cfg_data[2:0];
                REG_TIMING_ADDRESS: cfg_next.timing_address = cfg_data;
                REG_COMMAND_ONE:    cfg_next.command_one    = cfg_data;
                REG_COMMAND_TWO:    cfg_next.command_two    = cfg_data;
                REG_DEVICE_ADDRESS: cfg_next.device_address = cfg_data[6:0];
                REG_SETUP_TICKS:    cfg_next.setup_ticks    = cfg_data;
                REG_HOLD_TICKS:     cfg_next.hold_ticks     = cfg_data;
                REG_PERIOD_TICKS:   cfg_next.period_ticks   = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{head_bits: 3'd0, timing_address: 8'd0, command_one: 8'd0,
                         command_two: 8'd0, device_address: 7'd0,
                         setup_ticks: SETUP_RESET, hold_ticks: HOLD_RESET,
                         period_ticks: PERIOD_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dnss_core #(
        .STORE_WAIT_TICKS (STORE_WAIT_TICKS),
        .ACK_POLL_LIMIT   (ACK_POLL_LIMIT),
        .COMMAND_REPEATS  (COMMAND_REPEATS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (in_accept),
        .cfg           (cfg_reg),
        .start_request (start_request),
        .sda_sample    (sda_sample),
        .res           (res)
    );

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign clock_line      = res_reg.clock_line;
    assign data_level      = res_reg.data_level;
    assign data_drive      = res_reg.data_drive;
    assign bus_handed_back = res_reg.bus_handed_back;
    assign busy_res        = res_reg.busy_res;
    assign finished        = res_reg.finished;

endmodule

// ===== hdl/dnss_checker.sv =====
// port-level checks for the store sequencer, bound to the top level
`include "dac_nvm_store_bitbang_sequencer_defines.svh"

module dnss_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic clock_line,
    input logic data_level,
    input logic data_drive,
    input logic bus_handed_back,
    input logic busy_res,
    input logic finished
);

    // stalled result word holds
    `DNSS_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(clock_line) && $stable(data_level) && $stable(data_drive) && $stable(finished), "result word changed while stalled")

    // idle and busy are exclusive
    `DNSS_ASSERT_IMPLIES(a_busy_excl, out_valid, bus_handed_back != busy_res, "busy and hand-back disagree")

    // completion only with the bus handed back
    `DNSS_ASSERT_IMPLIES(a_fin_idle, out_valid && finished, bus_handed_back, "finish without hand-back")

    // idle lines released with scl and sda high
    `DNSS_ASSERT_IMPLIES(a_idle_lines, out_valid && bus_handed_back, clock_line && data_level && !data_drive, "idle lines not released")

    // completion pulse lasts one word
    `DNSS_ASSERT_NEXT(a_fin_pulse, out_valid && out_ready && finished, !(out_valid && finished), "finish pulse repeated")

endmodule

bind dac_nvm_store_bitbang_sequencer dnss_checker u_checker (.*);
